// File: rtl/rrts_pkg.sv
package rrts_pkg;

   localparam int THREADS = 16;
   localparam int IDX_W   = $clog2(THREADS);
   localparam int CNT_W   = $clog2(THREADS + 1);

   typedef enum logic [1:0] {
      OP_CREATE  = 2'd0,
      OP_YIELD   = 2'd1,
      OP_BLOCK   = 2'd2,
      OP_UNBLOCK = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ERR_OK          = 2'd0,
      ERR_NOT_BLOCKED = 2'd1,
      ERR_EXISTS      = 2'd2
   } err_type;

   typedef enum logic {
      SCH_IDLE,
      SCH_EXEC
   } sched_state_type;

   typedef logic [2:0] status_type;

   localparam status_type ST_FREE    = 3'd0;
   localparam status_type ST_RUNNING = 3'd1;
   localparam status_type ST_READY   = 3'd2;
   localparam status_type ST_BLOCKED = 3'd3;
   localparam status_type ST_HANGING = 3'd5;

   localparam logic [1:0] KIND_INVALID = 2'd3;

   typedef struct packed {
      opcode_type opcode;
      logic [3:0] thread_id;
      logic [1:0] block_kind;
   } req_type;

   typedef struct packed {
      logic [3:0] running_thread;
      logic       switched;
      err_type    error_code;
   } rsp_type;

endpackage

// File: rtl/rrts_ram.sv
module rrts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/round_robin_thread_scheduler.sv
// Round-robin thread scheduler.
// Input channel (req_*): one scheduling event per transaction: create, yield,
// block of the running thread, or unblock. Result channel (rsp_*): exactly one
// transaction per event, with the running thread after the event, whether a
// dispatch happened, and an error code. Config channel (csr_*): writes the idle
// thread id, always ready; write it only while no event is in flight.
// In the accept cycle the thread status table and the ready deque are read
// at the event's thread id and at the deque head; in the execute state, once
// the output register is free, the block writes each memory at most once and
// loads the result register. The next event is accepted only after that, so
// the block does not take a new event before the last one is done, because
// the reads of the two memories are registered.
// The running thread's status is implied by the running id and not stored.
// A finished result waits in the output register while rsp_stall is high; a
// following event may be accepted meanwhile but is held before its memory
// update until the register is free.
// Reset (synchronous): thread 0 running, every other thread free, deque
// empty, idle thread 1. No clearing pass of the memories.
module round_robin_thread_scheduler (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  rrts_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rrts_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [3:0]       csr_data
);
   import rrts_pkg::*;

   sched_state_type   state_ff, state_in;
   req_type           item_ff;
   logic [IDX_W-1:0]  running_ff, running_in;
   logic [IDX_W-1:0]  head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [3:0]        idle_ff;
   logic [THREADS-1:0] stat_vld_ff, stat_vld_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic              req_accept;
   logic              out_free;
   logic              stat_we, dq_we;
   logic [IDX_W-1:0]  stat_waddr, dq_waddr, dq_wdata;
   status_type        stat_wdata, stat_rd, stat_cur;
   logic [IDX_W-1:0]  dq_rd, tail, next_id;
   logic              full;
   logic [1:0]        kind;

   rrts_ram #(.WIDTH(3), .DEPTH(THREADS)) u_status_ram (
      .clock   (clock),
      .wr_en   (stat_we),
      .wr_addr (stat_waddr),
      .wr_data (stat_wdata),
      .rd_en   (req_accept),
      .rd_addr (req_data.thread_id[IDX_W-1:0]),
      .rd_data (stat_rd)
   );

   rrts_ram #(.WIDTH(IDX_W), .DEPTH(THREADS)) u_deque_ram (
      .clock   (clock),
      .wr_en   (dq_we),
      .wr_addr (dq_waddr),
      .wr_data (dq_wdata),
      .rd_en   (req_accept),
      .rd_addr (head_ff),
      .rd_data (dq_rd)
   );

   assign req_stall  = (state_ff != SCH_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   assign tail = head_ff + count_ff[IDX_W-1:0];
   assign full = (count_ff == CNT_W'(THREADS));
   assign kind = (item_ff.block_kind == KIND_INVALID) ? 2'd0 : item_ff.block_kind;

   // running thread reads as running; never-written entries read as free
   always_comb begin
      if (item_ff.thread_id[IDX_W-1:0] == running_ff) begin
         stat_cur = ST_RUNNING;
      end else if (stat_vld_ff[item_ff.thread_id[IDX_W-1:0]]) begin
         stat_cur = stat_rd;
      end else begin
         stat_cur = ST_FREE;
      end
   end

   always_comb begin
      state_in     = state_ff;
      running_in   = running_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      stat_vld_in  = stat_vld_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      stat_we      = 1'b0;
      stat_waddr   = item_ff.thread_id[IDX_W-1:0];
      stat_wdata   = ST_READY;
      dq_we        = 1'b0;
      dq_waddr     = tail;
      dq_wdata     = item_ff.thread_id[IDX_W-1:0];
      next_id      = running_ff;

      case (state_ff)
         SCH_IDLE: begin
            if (req_accept) begin
               state_in = SCH_EXEC;
            end
         end
         SCH_EXEC: begin
            if (out_free) begin
               rsp_data_in.switched   = 1'b0;
               rsp_data_in.error_code = ERR_OK;
               case (item_ff.opcode)
                  OP_CREATE: begin
                     if (stat_cur != ST_FREE) begin
                        rsp_data_in.error_code = ERR_EXISTS;
                     end else begin
                        stat_we = 1'b1;
                        if (!full) begin
                           dq_we    = 1'b1;
                           count_in = count_ff + CNT_W'(1);
                        end
                     end
                  end
                  OP_YIELD: begin
                     stat_we    = 1'b1;
                     stat_waddr = running_ff;
                     dq_we      = !full;
                     dq_wdata   = running_ff;
                     // an empty deque pops back the thread just pushed
                     next_id    = (count_ff == '0) ? running_ff : dq_rd;
                     head_in    = head_ff + IDX_W'(1);
                     count_in   = full ? count_ff - CNT_W'(1) : count_ff;
                     rsp_data_in.switched = 1'b1;
                  end
                  OP_BLOCK: begin
                     stat_we    = 1'b1;
                     stat_waddr = running_ff;
                     stat_wdata = ST_BLOCKED + status_type'(kind);
                     if (count_ff == '0) begin
                        next_id = idle_ff[IDX_W-1:0];
                     end else begin
                        next_id  = dq_rd;
                        head_in  = head_ff + IDX_W'(1);
                        count_in = count_ff - CNT_W'(1);
                     end
                     rsp_data_in.switched = 1'b1;
                  end
                  OP_UNBLOCK: begin
                     if (stat_cur < ST_BLOCKED || stat_cur > ST_HANGING) begin
                        rsp_data_in.error_code = ERR_NOT_BLOCKED;
                     end else begin
                        stat_we = 1'b1;
                        if (!full) begin
                           dq_we    = 1'b1;
                           dq_waddr = head_ff - IDX_W'(1);
                           head_in  = head_ff - IDX_W'(1);
                           count_in = count_ff + CNT_W'(1);
                        end
                     end
                  end
                  default: begin
                  end
               endcase
               if (stat_we) begin
                  stat_vld_in[stat_waddr] = 1'b1;
               end
               running_in                 = next_id;
               rsp_data_in.running_thread = 4'(next_id);
               rsp_valid_in               = 1'b1;
               state_in                   = SCH_IDLE;
            end
         end
         default: begin
            state_in = SCH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SCH_IDLE;
         running_ff   <= '0;
         head_ff      <= '0;
         count_ff     <= '0;
         idle_ff      <= 4'd1;
         stat_vld_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         running_ff   <= running_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         stat_vld_ff  <= stat_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            idle_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (req_accept) begin
         item_ff <= req_data;
      end
   end

endmodule

// File: rtl/rrts_checker.sv
module rrts_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input rrts_pkg::rsp_type rsp_data
);
   import rrts_pkg::*;

   // hold a stalled result transaction
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // one event at a time: stall right after an accepted transaction
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("event accepted while busy");

   // no result appears in the cycle after an accept
   a_no_early_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !$rose(rsp_valid))
      else $error("result appeared too early");

   // a dispatch never reports an error
   a_switch_no_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.switched |-> rsp_data.error_code == ERR_OK)
      else $error("dispatch with error code");

endmodule

bind round_robin_thread_scheduler rrts_checker u_rrts_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// File: sim/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import rrts_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam int LONG_HOLD   = 400;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   req_type    req_data = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   rsp_type    rsp_data;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [3:0] csr_data = '0;

   bit quiet;
   bit hold_request;
   int unsigned cycles;

   class sched_scoreboard;
      status_type status_tbl[THREADS];
      logic [3:0] ready_q[THREADS];
      logic [3:0] q_head;
      logic [4:0] q_count;
      logic [3:0] running;
      logic [3:0] idle_id;
      rsp_type    expected_q[$];
      int         mismatches;

      function new();
         foreach (status_tbl[t]) status_tbl[t] = ST_FREE;
         foreach (ready_q[t]) ready_q[t] = '0;
         status_tbl[0] = ST_RUNNING;
         q_head = '0;
         q_count = '0;
         running = '0;
         idle_id = 4'd1;
         mismatches = 0;
      endfunction

      function bit is_blocked(status_type s);
         return s >= ST_BLOCKED && s <= ST_HANGING;
      endfunction

      function void push_tail(logic [3:0] id);
         logic [3:0] slot;
         slot = q_head + q_count[3:0];
         if (q_count < THREADS) begin
            ready_q[slot] = id;
            q_count++;
         end
      endfunction

      // pop the head, or wake the idle thread when nothing is ready
      function void dispatch();
         if (q_count == 0) begin
            running = idle_id;
         end else begin
            running = ready_q[q_head];
            q_head = q_head + 4'd1;
            q_count--;
         end
         status_tbl[running] = ST_RUNNING;
      endfunction

      function logic [3:0] pick_thread(bit want_blocked);
         logic [3:0] cand[$];
         for (int t = 0; t < THREADS; t++) begin
            if (want_blocked ? is_blocked(status_tbl[t]) : status_tbl[t] == ST_FREE)
               cand.push_back(t[3:0]);
         end
         if (cand.size() == 0) return 4'($urandom_range(0, THREADS - 1));
         return cand[$urandom_range(0, cand.size() - 1)];
      endfunction

      function void note_event(req_type r);
         rsp_type    e;
         logic [3:0] cur;
         logic [1:0] kind;
         e.switched = 1'b0;
         e.error_code = ERR_OK;
         cur = running;
         case (r.opcode)
            OP_CREATE: begin
               if (status_tbl[r.thread_id] != ST_FREE) begin
                  e.error_code = ERR_EXISTS;
               end else begin
                  status_tbl[r.thread_id] = ST_READY;
                  push_tail(r.thread_id);
               end
            end
            OP_YIELD: begin
               status_tbl[cur] = ST_READY;
               push_tail(cur);
               dispatch();
               e.switched = 1'b1;
            end
            OP_BLOCK: begin
               // an invalid kind falls back to plain blocked
               kind = (r.block_kind == KIND_INVALID) ? 2'd0 : r.block_kind;
               status_tbl[cur] = ST_BLOCKED + {1'b0, kind};
               dispatch();
               e.switched = 1'b1;
            end
            default: begin
               if (!is_blocked(status_tbl[r.thread_id])) begin
                  e.error_code = ERR_NOT_BLOCKED;
               end else if (q_count < THREADS) begin
                  status_tbl[r.thread_id] = ST_READY;
                  q_head = q_head - 4'd1;
                  ready_q[q_head] = r.thread_id;
                  q_count++;
               end else begin
                  status_tbl[r.thread_id] = ST_READY;
               end
            end
         endcase
         e.running_thread = running;
         expected_q.push_back(e);
      endfunction

      function void check_result(rsp_type a);
         rsp_type e;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected rsp transaction: thread %0d switched %0d error %0d",
                        a.running_thread, a.switched, a.error_code);
            return;
         end
         e = expected_q.pop_front();
         if (a.running_thread !== e.running_thread || a.switched !== e.switched ||
             a.error_code !== e.error_code) begin
            mismatches++;
            if (mismatches <= 10)
               $display(
                  "rsp mismatch: exp thread %0d sw %0d err %0d, got thread %0d sw %0d err %0d",
                  e.running_thread, e.switched, e.error_code,
                  a.running_thread, a.switched, a.error_code);
         end
      endfunction
   endclass

   sched_scoreboard sb = new();

   round_robin_thread_scheduler i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_data);
         if (req_valid && !req_stall) sb.note_event(req_data);
         if (csr_valid && csr_ready) sb.idle_id = csr_data;
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // receiver side: random stall bursts plus one long hold-off
   initial begin
      bit hold_done;
      hold_done = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (!quiet && $urandom_range(0, 2) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   end

   task automatic send_event(input opcode_type op, input logic [3:0] tid,
                             input logic [1:0] kind);
      req_type r;
      int      gap;
      r.opcode = op;
      r.thread_id = tid;
      r.block_kind = kind;
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      gap = (!quiet && $urandom_range(0, 4) == 0) ? $urandom_range(1, 12) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_idle(input logic [3:0] id);
      drain();
      csr_valid <= 1'b1;
      csr_data <= id;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic random_events(input int count);
      int          pick;
      opcode_type  op;
      logic [3:0]  tid;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         tid = 4'($urandom_range(0, THREADS - 1));
         if (pick < 25) begin
            op = OP_CREATE;
            if ($urandom_range(0, 3) != 0) tid = sb.pick_thread(1'b0);
         end else if (pick < 55) begin
            op = OP_YIELD;
         end else if (pick < 75) begin
            op = OP_BLOCK;
         end else begin
            op = OP_UNBLOCK;
            if ($urandom_range(0, 3) != 0) tid = sb.pick_thread(1'b1);
         end
         send_event(op, tid, 2'($urandom_range(0, 3)));
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // yield alone, then block with nothing ready so the idle thread runs
      send_event(OP_YIELD, 4'd0, 2'd0);
      send_event(OP_BLOCK, 4'd0, 2'd0);
      send_event(OP_CREATE, 4'd0, 2'd0);
      send_event(OP_CREATE, 4'd15, 2'd0);
      send_event(OP_CREATE, 4'd15, 2'd3);
      send_event(OP_UNBLOCK, 4'd0, 2'd0);
      send_event(OP_UNBLOCK, 4'd0, 2'd0);
      send_event(OP_UNBLOCK, 4'd5, 2'd0);
      send_event(OP_YIELD, 4'd9, 2'd3);
      send_event(OP_BLOCK, 4'd0, 2'd1);
      send_event(OP_BLOCK, 4'd0, 2'd2);
      send_event(OP_BLOCK, 4'd0, 2'd3);
      send_event(OP_UNBLOCK, 4'd0, 2'd0);
      send_event(OP_UNBLOCK, 4'd15, 2'd0);
      send_event(OP_CREATE, 4'd1, 2'd0);
      send_event(OP_UNBLOCK, 4'd1, 2'd0);
      send_event(OP_YIELD, 4'd15, 2'd2);
      send_event(OP_CREATE, 4'd7, 2'd3);
      send_event(OP_BLOCK, 4'd15, 2'd0);

      write_idle(4'd0);
      hold_request = 1'b1;
      random_events(370);
      write_idle(4'd15);
      random_events(370);
      write_idle(4'($urandom_range(0, 15)));
      random_events(370);
      write_idle(4'($urandom_range(0, 15)));
      random_events(370);
      quiet = 1'b1;
      write_idle(4'($urandom_range(0, 15)));
      random_events(370);

      drain();
      repeat (20) @(posedge clock);
      if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
